[rtl/core/base64_to_le_word_decoder_assert.svh]
// Assertion macros for the base64 word decoder checker.
// Clock is clock, reset is reset (synchronous, active high); no other dependencies.
`ifndef BASE64_TO_LE_WORD_DECODER_ASSERT_SVH
`define BASE64_TO_LE_WORD_DECODER_ASSERT_SVH

// Checked only outside reset.
`define B64W_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every edge, reset included.
`define B64W_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[rtl/core/b64w_pkg.sv]
// Shared types, constants and character decode for the base64 word decoder.
// No dependencies.
`timescale 1ns / 1ps

package b64w_pkg;

   localparam int unsigned CAP_W         = 17;
   localparam logic [CAP_W-1:0] MAX_ROM_WORDS = 17'd65536;

   localparam logic [7:0] CH_PAD = 8'h3D;   // '='

   // status codes (error codes share the same values)
   localparam logic [1:0] ST_RUNNING  = 2'd0;
   localparam logic [1:0] ST_SUCCESS  = 2'd1;
   localparam logic [1:0] ST_BAD_CHAR = 2'd2;
   localparam logic [1:0] ST_CAPACITY = 2'd3;

   typedef struct packed {
      logic       hit;
      logic [5:0] value;
   } sextet_type;

   function automatic sextet_type b64w_sextet(input logic [7:0] c);
      sextet_type s;
      s.hit   = 1'b1;
      s.value = 6'd0;
      case (c) inside
         [8'h41:8'h5A]: s.value = 6'(c - 8'h41);
         [8'h61:8'h7A]: s.value = 6'(c - 8'h61 + 8'd26);
         [8'h30:8'h39]: s.value = 6'(c - 8'h30 + 8'd52);
         8'h2B:         s.value = 6'd62;
         8'h2F:         s.value = 6'd63;
         default:       s.hit   = 1'b0;
      endcase
      return s;
   endfunction

   function automatic logic b64w_is_blank(input logic [7:0] c);
      logic r;
      case (c) inside
         8'h20, [8'h09:8'h0D]: r = 1'b1;
         default:              r = 1'b0;
      endcase
      return r;
   endfunction

endpackage

[rtl/core/base64_to_le_word_decoder.sv]
// Base64 text to little-endian 32-bit word decoder, top level.
// Depends on b64w_pkg.
`timescale 1ns / 1ps
//
//  channel | dir | tdata                                   | tuser      | tlast
//  --------+-----+-----------------------------------------+------------+---------
//  req_    | in  | [7:0] char_code                         | -          | end_mark
//  rsp_    | out | [31:0] word_value [47:32] word_index    | word_valid | done_res
//          |     | [49:48] status, [55:50] zero            |            |
//  csr_    | in  | csr_wdata = rom_words, written when csr_wen        |
//
//  One request per cycle unless a stalled response backs the input up; a
//  request is decoded while it sits in the input register, and its response
//  (if any) is loaded into the output register.
//  A stalled response holds the output register; the input register keeps
//  filling, so requests stop only when both registers are full.
//  reset (synchronous) empties both registers, clears decode state and sets
//  rom_words to 65536.

module base64_to_le_word_decoder
   import b64w_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,    // [7:0] char_code
   input  logic             req_tlast,    // end_mark
   // response channel
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [55:0]      rsp_tdata,    // [31:0] word_value, [47:32] word_index,
                                          // [49:48] status, [55:50] zero
   output logic             rsp_tuser,    // word_valid
   output logic             rsp_tlast,    // done_res
   // configuration
   input  logic             csr_wen,
   input  logic [CAP_W-1:0] csr_wdata     // rom_words
);

   // input register
   logic        in_vld_ff, in_vld_in;
   logic [7:0]  in_char_ff;
   logic        in_end_ff;

   // decode state
   logic [1:0]       gp_ff,   gp_in;      // characters held in the group
   logic [23:0]      sext_ff, sext_in;    // sextets, oldest highest
   logic [3:0]       pad_ff,  pad_in;     // '=' seen per group position
   logic [23:0]      part_ff, part_in;    // bytes of the word in progress
   logic [1:0]       biw_ff,  biw_in;     // bytes held in part_ff
   logic [CAP_W-1:0] wc_ff,   wc_in;      // completed words
   logic             stop_ff, stop_in;
   logic [1:0]       err_ff,  err_in;
   logic [CAP_W-1:0] cap_ff,  cap_in;     // clamped rom_words

   // output register
   logic        out_vld_ff;
   logic [31:0] out_word_ff;
   logic [15:0] out_idx_ff;
   logic [1:0]  out_st_ff;
   logic        out_wv_ff;
   logic        out_done_ff;

   // decode results
   logic        fire;
   logic        res_vld;
   logic [31:0] res_word;
   logic [15:0] res_idx;
   logic [1:0]  res_st;
   logic        res_wv;
   logic        res_done;

   sextet_type  sx;
   logic        is_pad;
   logic        is_blank;
   logic [23:0] sext_new;
   logic [3:0]  pad_new;
   logic [1:0]  nbytes;
   logic [1:0]  nkeep;
   logic [2:0]  fill;
   logic [2:0]  total;
   logic        wc_full;
   logic        wc_last;
   logic        cap_err;
   logic [23:0] grp_le;
   logic [23:0] grp_mask;
   logic [47:0] merged;

   assign fire       = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || fire;
   assign in_vld_in  = req_tvalid;

   assign sx       = b64w_sextet(in_char_ff);
   assign is_pad   = (in_char_ff == CH_PAD);
   assign is_blank = b64w_is_blank(in_char_ff);

   // clamp rom_words into 1 .. MAX_ROM_WORDS at write time
   always_comb begin
      if (csr_wdata == '0) begin
         cap_in = CAP_W'(1);
      end else if (csr_wdata > MAX_ROM_WORDS) begin
         cap_in = MAX_ROM_WORDS;
      end else begin
         cap_in = csr_wdata;
      end
   end

   // group completion arithmetic
   always_comb begin
      sext_new = {sext_ff[17:0], (is_pad ? 6'h3F : sx.value)};
      pad_new  = pad_ff;
      pad_new[gp_ff] = pad_ff[gp_ff] | is_pad;

      if (pad_new[2]) begin
         nbytes = 2'd1;
      end else if (pad_new[3]) begin
         nbytes = 2'd2;
      end else begin
         nbytes = 2'd3;
      end

      fill    = {1'b0, biw_ff} + {1'b0, nbytes};
      wc_full = (wc_ff >= cap_ff);
      wc_last = ({1'b0, wc_ff} + 18'd1) >= {1'b0, cap_ff};

      // capacity: no byte once the word count reaches capacity; bytes past a
      // word that fills the last slot are dropped
      if (wc_full) begin
         nkeep   = 2'd0;
         cap_err = 1'b1;
      end else if (fill >= 3'd4 && wc_last) begin
         nkeep   = 2'(3'd4 - {1'b0, biw_ff});
         cap_err = (fill > 3'd4);
      end else begin
         nkeep   = nbytes;
         cap_err = 1'b0;
      end

      case (nkeep)
         2'd0:    grp_mask = 24'h000000;
         2'd1:    grp_mask = 24'h0000FF;
         2'd2:    grp_mask = 24'h00FFFF;
         default: grp_mask = 24'hFFFFFF;
      endcase

      grp_le = {sext_new[7:0], sext_new[15:8], sext_new[23:16]} & grp_mask;
      merged = {24'h000000, part_ff} | ({24'h000000, grp_le} << {biw_ff, 3'b000});
      total  = {1'b0, biw_ff} + {1'b0, nkeep};
   end

   // per-request state update
   always_comb begin
      gp_in    = gp_ff;
      sext_in  = sext_ff;
      pad_in   = pad_ff;
      part_in  = part_ff;
      biw_in   = biw_ff;
      wc_in    = wc_ff;
      stop_in  = stop_ff;
      err_in   = err_ff;
      res_vld  = 1'b0;
      res_word = '0;
      res_idx  = '0;
      res_st   = ST_RUNNING;
      res_wv   = 1'b0;
      res_done = 1'b0;

      if (fire) begin
         if (in_end_ff) begin
            res_vld  = 1'b1;
            res_done = 1'b1;
            if (err_ff != ST_RUNNING) begin
               res_st = err_ff;
            end else if (!stop_ff && gp_ff != 2'd0) begin
               res_st = ST_BAD_CHAR;   // text ended inside a group
            end else begin
               res_st = ST_SUCCESS;
            end
            gp_in   = '0;
            sext_in = '0;
            pad_in  = '0;
            part_in = '0;
            biw_in  = '0;
            wc_in   = '0;
            stop_in = 1'b0;
            err_in  = ST_RUNNING;
         end else if (!stop_ff) begin
            if (gp_ff == 2'd0 && is_blank) begin
               // whitespace between groups
            end else if (gp_ff == 2'd0 && is_pad) begin
               stop_in = 1'b1;          // terminating '='
            end else if (!is_pad && !sx.hit) begin
               stop_in = 1'b1;
               err_in  = ST_BAD_CHAR;
            end else if (gp_ff != 2'd3) begin
               gp_in   = gp_ff + 2'd1;
               sext_in = sext_new;
               pad_in  = pad_new;
            end else begin
               gp_in   = '0;
               sext_in = '0;
               pad_in  = '0;
               if (total >= 3'd4) begin
                  res_vld  = 1'b1;
                  res_wv   = 1'b1;
                  res_word = merged[31:0];
                  res_idx  = wc_ff[15:0];
                  wc_in    = wc_ff + CAP_W'(1);
                  part_in  = {8'h00, merged[47:32]};
                  biw_in   = 2'(total - 3'd4);
               end else begin
                  part_in  = merged[23:0];
                  biw_in   = total[1:0];
               end
               if (cap_err) begin
                  stop_in = 1'b1;
                  err_in  = ST_CAPACITY;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         gp_ff      <= '0;
         sext_ff    <= '0;
         pad_ff     <= '0;
         part_ff    <= '0;
         biw_ff     <= '0;
         wc_ff      <= '0;
         stop_ff    <= 1'b0;
         err_ff     <= ST_RUNNING;
         cap_ff     <= MAX_ROM_WORDS;
      end else begin
         if (req_tready) begin
            in_vld_ff <= in_vld_in;
         end
         if (!out_vld_ff || rsp_tready) begin
            out_vld_ff <= fire && res_vld;
         end
         gp_ff   <= gp_in;
         sext_ff <= sext_in;
         pad_ff  <= pad_in;
         part_ff <= part_in;
         biw_ff  <= biw_in;
         wc_ff   <= wc_in;
         stop_ff <= stop_in;
         err_ff  <= err_in;
         if (csr_wen) begin
            cap_ff <= cap_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_char_ff <= req_tdata;
         in_end_ff  <= req_tlast;
      end
      if (fire && res_vld) begin
         out_word_ff <= res_word;
         out_idx_ff  <= res_idx;
         out_st_ff   <= res_st;
         out_wv_ff   <= res_wv;
         out_done_ff <= res_done;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {6'b000000, out_st_ff, out_idx_ff, out_word_ff};
   assign rsp_tuser  = out_wv_ff;
   assign rsp_tlast  = out_done_ff;

endmodule

[rtl/core/b64w_checker.sv]
// Port-level checker for the base64 word decoder, bound to the top level.
// Depends on b64w_pkg and base64_to_le_word_decoder_assert.svh.
`timescale 1ns / 1ps
`include "base64_to_le_word_decoder_assert.svh"

module b64w_checker
   import b64w_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic [7:0]       req_tdata,
   input logic             req_tlast,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [55:0]      rsp_tdata,
   input logic             rsp_tuser,
   input logic             rsp_tlast,
   input logic             csr_wen,
   input logic [CAP_W-1:0] csr_wdata
);

   logic [1:0] rsp_status;

   assign rsp_status = rsp_tdata[49:48];

   // a stalled response keeps its contents
   `B64W_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "response changed while stalled")

   // a word response is never final and always reports running
   `B64W_ASSERT(a_word_running, rsp_tvalid && rsp_tuser |-> !rsp_tlast && rsp_status == ST_RUNNING, "word response with final status")

   // every response is either a word or a final status, never both or neither
   `B64W_ASSERT(a_final_status, rsp_tvalid && !rsp_tuser |-> rsp_tlast && rsp_status != ST_RUNNING && rsp_tdata[47:0] == 48'd0, "malformed final response")

   // offered requests and register writes carry known values
   `B64W_ASSERT(a_inputs_known, !$isunknown(req_tvalid) && !$isunknown(csr_wen) && (!req_tvalid || (!$isunknown(req_tdata) && !$isunknown(req_tlast))) && (!csr_wen || !$isunknown(csr_wdata)), "unknown value on an input")

   // reset empties both registers
   `B64W_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_tvalid && req_tready, "pipeline not empty after reset")

endmodule

bind base64_to_le_word_decoder b64w_checker u_b64w_checker (.*);

[bench/tb.sv]
// Self-checking testbench for base64_to_le_word_decoder: drives base64 text, predicts words.
// Depends on b64w_pkg and the decoder RTL; needs no files or arguments.
`timescale 1ns / 1ps

module tb;
   import b64w_pkg::*;

   localparam int CYCLE_LIMIT  = 500000;  // far above the slowest legal run
   localparam int RANDOM_CHARS = 450;     // requests sent by the random tests

   // one response as the decoder should present it
   typedef struct {
      logic [31:0] value;
      logic [15:0] index;
      logic        valid;
      logic [1:0]  status;
      logic        done;
   } word_rsp_type;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [7:0]       req_tdata  = 8'h00;  // [7:0] char_code
   logic             req_tlast  = 1'b0;   // end_mark
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [55:0]      rsp_tdata;           // [31:0] word_value, [47:32] word_index,
                                          // [49:48] status, [55:50] zero
   logic             rsp_tuser;           // word_valid
   logic             rsp_tlast;           // done_res
   logic             csr_wen    = 1'b0;
   logic [CAP_W-1:0] csr_wdata  = '0;     // rom_words

   base64_to_le_word_decoder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Decoder state as predicted on our side
   // ---------------------------------------------------------------------
   string            b64_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
   logic [CAP_W-1:0] rom_words_set;   // last value written to the register
   logic [1:0]       grp_pos;         // characters held in the current group
   logic [23:0]      sext;            // group sextets, oldest in the top bits
   logic [3:0]       pads;            // '=' seen at each group position
   logic [23:0]      part;            // bytes of the word under construction
   logic [1:0]       held;            // bytes held in part
   logic [CAP_W-1:0] words_done;      // completed words in this text
   bit               halted;          // text stopped, characters ignored
   logic [1:0]       text_err;        // ST_RUNNING while no error

   word_rsp_type     decoded_words[$];  // responses still owed by the decoder
   int               mismatch_count = 0;
   int               chars_used     = 0;  // requests accepted so far
   int               cycle_count    = 0;

   // stimulus knobs
   bit               gaps_on  = 1'b1;     // sender idles now and then
   bit               stall_on = 1'b1;     // receiver stalls now and then
   int               hold_request = 0;    // ask the receiver for a long hold-off
   int               hold_left    = 0;

   word_rsp_type     want;

   function automatic int sextet_value(logic [7:0] c);
      if (c >= "A" && c <= "Z") return c - "A";
      if (c >= "a" && c <= "z") return c - "a" + 26;
      if (c >= "0" && c <= "9") return c - "0" + 52;
      if (c == "+") return 62;
      if (c == "/") return 63;
      return -1;
   endfunction

   function automatic bit is_space(logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   // 0 behaves as 1, anything above the memory size as the memory size
   function automatic logic [CAP_W-1:0] clamp_capacity(logic [CAP_W-1:0] v);
      if (v == '0) return CAP_W'(1);
      if (v > MAX_ROM_WORDS) return MAX_ROM_WORDS;
      return v;
   endfunction

   function automatic void clear_text();
      grp_pos    = '0;
      sext       = '0;
      pads       = '0;
      part       = '0;
      held       = '0;
      words_done = '0;
      halted     = 1'b0;
      text_err   = ST_RUNNING;
   endfunction

   // Advance the predicted state by one accepted request and queue the
   // response it causes, if any.
   task automatic decode_item(input logic [7:0] c, input logic last);
      word_rsp_type     r;
      int               sx;
      int               nb;
      int               k;
      logic [7:0]       b;
      logic [CAP_W-1:0] idx;
      logic [31:0]      word;
      bit               got_word;
      got_word = 1'b0;
      word     = '0;
      r = '{value: '0, index: '0, valid: 1'b0, status: ST_RUNNING, done: 1'b0};
      if (last) begin
         // final status: sticky error first, then an unfinished group
         if (text_err != ST_RUNNING)
            r.status = text_err;
         else if (!halted && grp_pos != 0)
            r.status = ST_BAD_CHAR;
         else
            r.status = ST_SUCCESS;
         r.done = 1'b1;
         decoded_words.push_back(r);
         clear_text();
         return;
      end
      if (halted) return;
      if (grp_pos == 0 && is_space(c)) return;  // blanks between groups
      if (grp_pos == 0 && c == CH_PAD) begin    // '=' opening a group ends the text
         halted = 1'b1;
         return;
      end
      if (c == CH_PAD) begin
         sx = 63;
         pads[grp_pos] = 1'b1;
      end else begin
         sx = sextet_value(c);
         if (sx < 0) begin
            text_err = ST_BAD_CHAR;
            halted   = 1'b1;
            return;
         end
      end
      sext = {sext[17:0], 6'(sx)};
      if (grp_pos != 2'd3) begin
         grp_pos++;
         return;
      end
      // group complete: padding in the third slot wins over the fourth
      nb = pads[2] ? 1 : (pads[3] ? 2 : 3);
      for (k = 0; k < nb; k++) begin
         b = sext[23-8*k -: 8];
         if (words_done >= clamp_capacity(rom_words_set)) begin
            text_err = ST_CAPACITY;
            halted   = 1'b1;
            break;
         end
         if (held == 2'd3) begin
            word       = {b, part};
            part       = '0;
            held       = '0;
            words_done = words_done + 1'b1;
            got_word   = 1'b1;
         end else begin
            part[8*held +: 8] = b;
            held++;
         end
      end
      grp_pos = '0;
      sext    = '0;
      pads    = '0;
      if (got_word) begin
         idx     = words_done - 1'b1;
         r.value = word;
         r.index = idx[15:0];
         r.valid = 1'b1;
         decoded_words.push_back(r);
      end
   endtask

   // ---------------------------------------------------------------------
   // Response side: ready generation and checking
   // ---------------------------------------------------------------------
   // A hold-off request is picked up here and counted down in this process;
   // the sender keeps offering requests meanwhile.
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (stall_on)
         rsp_tready <= ($urandom_range(99) >= 9);
      else
         rsp_tready <= 1'b1;
   end

   function automatic void check_field(string what, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, exp_v, act_v);
         mismatch_count++;
      end
   endfunction

   // Values sampled right after the edge are the pre-edge ones, so the
   // handshake seen here is the one the decoder saw.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (decoded_words.size() == 0) begin
            $display("%0t ns: response with none expected, expected nothing, actual %h %b %b",
                     $time, rsp_tdata, rsp_tuser, rsp_tlast);
            mismatch_count++;
         end else begin
            want = decoded_words.pop_front();
            check_field("word_value", want.value, rsp_tdata[31:0]);
            check_field("word_index", 32'(want.index), 32'(rsp_tdata[47:32]));
            check_field("word_valid", 32'(want.valid), 32'(rsp_tuser));
            check_field("status",     32'(want.status), 32'(rsp_tdata[49:48]));
            check_field("done_res",   32'(want.done), 32'(rsp_tlast));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------
   // Offer one request and wait for it to be taken. valid stays high into
   // the next call unless that call opens an idle gap.
   task automatic send_char(input logic [7:0] c, input logic last);
      if (gaps_on && $urandom_range(99) < 9) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      chars_used++;
      decode_item(c, last);
   endtask

   // end-of-text request; the character field carries junk on purpose
   task automatic send_end();
      send_char(8'($urandom_range(255)), 1'b1);
   endtask

   task automatic send_string(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
   endtask

   // Sender goes quiet until every owed response is back, then lets the
   // pipeline run dry (two registers deep).
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (decoded_words.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // only called while the decoder is idle
   task automatic set_capacity(input logic [CAP_W-1:0] v);
      csr_wen   <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_wen   <= 1'b0;
      rom_words_set = v;
      @(posedge clock);
   endtask

   function automatic logic [7:0] alpha_char();
      return b64_chars[$urandom_range(63)];
   endfunction

   function automatic logic [7:0] blank_char();
      int pick;
      pick = $urandom_range(5);
      return (pick == 5) ? 8'h20 : 8'(8'h09 + pick);
   endfunction

   // Mostly well-formed groups with random content; a minority get padding
   // in odd places, stray bytes, blanks inside a group, an early '=' or a
   // truncated last group.
   task automatic send_random_text(input int max_groups);
      logic [7:0] grp[4];
      int         groups;
      int         kind;
      int         cut;
      groups = $urandom_range(0, max_groups);
      for (int g = 0; g < groups; g++) begin
         if ($urandom_range(3) == 0) send_char(blank_char(), 1'b0);
         for (int k = 0; k < 4; k++) grp[k] = alpha_char();
         kind = $urandom_range(99);
         cut  = 4;
         if (kind < 12) begin
            grp[2] = CH_PAD;
            grp[3] = CH_PAD;
         end else if (kind < 24)
            grp[3] = CH_PAD;
         else if (kind < 28)
            grp[$urandom_range(1, 3)] = CH_PAD;
         else if (kind < 33)
            grp[$urandom_range(0, 3)] = 8'($urandom_range(255));
         else if (kind < 36)
            grp[$urandom_range(1, 3)] = blank_char();
         else if (kind < 38)
            grp[0] = CH_PAD;
         else if (kind < 41)
            cut = $urandom_range(1, 3);
         for (int k = 0; k < cut; k++) send_char(grp[k], 1'b0);
         if (cut < 4) break;
      end
      send_end();
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // Register still at its reset value: full group, tab between groups,
   // one-byte and two-byte padding, all-ones sextets.
   task automatic test_directed_words();
      send_string("//+/\tzz==09A=");
      send_end();
      wait_idle();
   endtask

   // unfinished group, '=' opening a group with junk after it, empty text
   task automatic test_text_ends();
      send_string("AB");
      send_end();
      send_string("=Q");
      send_end();
      send_end();
      wait_idle();
   endtask

   // code zero, then a blank inside a group
   task automatic test_bad_chars();
      send_char(8'h00, 1'b0);
      send_end();
      send_string("A B");
      send_end();
      wait_idle();
   endtask

   // register 0 acts as one word: first word goes out, fifth byte overflows
   task automatic test_capacity_limit();
      set_capacity('0);
      send_string("AAAAAAAA");
      send_end();
      wait_idle();
      set_capacity(17'h1FFFF);  // above the memory size, clamps
   endtask

   // Receiver holds off long enough that both pipeline registers fill and
   // the request side backs up.
   task automatic test_backpressure();
      gaps_on      = 1'b0;
      hold_request = 300;
      for (int g = 0; g < 40; g++)
         for (int k = 0; k < 4; k++) send_char(alpha_char(), 1'b0);
      send_end();
      wait_idle();
      gaps_on = 1'b1;
   endtask

   task automatic test_random_texts();
      int start;
      start = chars_used;
      // default-sized memory, random idling on both sides
      set_capacity(17'd65537);
      while (chars_used - start < 130) send_random_text(8);
      wait_idle();
      // tiny memories so capacity errors are common; new size per text
      while (chars_used - start < 230) begin
         set_capacity(17'($urandom_range(0, 4)));
         send_random_text(8);
         wait_idle();
      end
      // long stretch with no idling at all
      gaps_on  = 1'b0;
      stall_on = 1'b0;
      set_capacity(MAX_ROM_WORDS);
      while (chars_used - start < 330) send_random_text(8);
      wait_idle();
      gaps_on  = 1'b1;
      stall_on = 1'b1;
      // any register value
      while (chars_used - start < RANDOM_CHARS) begin
         set_capacity(17'($urandom_range(0, 17'h1FFFF)));
         repeat ($urandom_range(1, 4)) send_random_text(8);
         wait_idle();
      end
   endtask

   initial begin
      rom_words_set = MAX_ROM_WORDS;  // register value after reset
      clear_text();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_words();
      test_text_ends();
      test_bad_chars();
      test_capacity_limit();
      test_backpressure();
      test_random_texts();
      wait_idle();
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
